// ===== rtl/tpsa_pkg.sv =====
// types, codes and default sizes shared by the priority slot allocator
// used by tpsa_search and thread_priority_slot_allocator_top
`default_nettype none

package tpsa_pkg;

  // default sizes for the top level parameters
  localparam int unsigned NumLevelsDef  = 64;
  localparam int unsigned CountWidthDef = 8;

  // fixed field widths of the stream payload
  localparam int unsigned FuncW = 3;
  localparam int unsigned ReqW  = 7;
  localparam int unsigned PrioW = 6;
  localparam int unsigned StatW = 3;

  // operation codes carried in the input tuser
  typedef enum logic [FuncW-1:0] {
    FUNC_ADD_GIVEN   = 3'd0,
    FUNC_ADD_LOWEST  = 3'd1,
    FUNC_ADD_HIGHEST = 3'd2,
    FUNC_ADD_BELOW   = 3'd3,
    FUNC_ADD_ABOVE   = 3'd4,
    FUNC_REMOVE      = 3'd5
  } func_e;

  // result status codes
  typedef enum logic [StatW-1:0] {
    STAT_OK    = 3'd0,
    STAT_RANGE = 3'd1,
    STAT_SAT   = 3'd2,
    STAT_EMPTY = 3'd3,
    STAT_FULL  = 3'd4
  } status_e;

  // count update chosen for the selected level
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_ADD  = 2'd1,
    OP_REM  = 2'd2
  } op_e;

  // control from the level search to the update stage
  typedef struct packed {
    op_e     op;
    status_e status;
  } srch_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/thread_priority_slot_allocator_top.sv =====
// top level of the thread priority slot allocator: count ram, bitmap, update
// depends on tpsa_pkg, tpsa_ram and tpsa_search
//
// Usage: one input transfer per request on the s_axis channel: tuser holds the
// operation code, tdata the given or reference level. Each request gives one
// m_axis transfer with the level taken or released and a status.
// Per-level thread counts live in a ram with registered read; a bitmap in
// flops marks levels whose count is nonzero, so a level whose bit is clear
// reads as zero and no clearing pass is needed after reset.
// On the input transfer the bitmap encoders pick the level and the ram read is
// issued. In the update step the count is checked, written back and the bitmap
// updated while the result is loaded into the output register.
// A new request is taken only after the update step of the previous one has
// finished, as the count ram is read, modified and written back for each
// request.
// A request may be taken while the previous result waits in the output
// register; if the receiver stalls, the update step holds until the register
// frees, and the input stays blocked.
// Reset (rst_ni low, asynchronous) empties all levels and drops the result.
`default_nettype none

module thread_priority_slot_allocator_top
  import tpsa_pkg::*;
#(
  parameter int unsigned NumLevels  = NumLevelsDef,
  parameter int unsigned CountWidth = CountWidthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [6:0] priority_req, [7] zero
  input  wire logic [2:0]  s_axis_tuser,   // [2:0] func
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [15:0] m_axis_tdata    // [5:0] assigned_priority, [8:6] status, rest zero
);

  localparam int unsigned LvlW = $clog2(NumLevels);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RMW  = 2'b10
  } fsm_e;

  fsm_e            state_q, state_d;
  logic [NumLevels-1:0] occ_q, occ_d;
  logic [LvlW-1:0] lvl_q;
  srch_ctrl_t      ctrl_q;
  logic            out_vld_q, out_vld_d;
  logic [PrioW-1:0] out_prio_q;
  status_e         out_stat_q;

  logic            in_xfer;
  logic            finish;
  logic [LvlW-1:0] srch_lvl;
  srch_ctrl_t      srch_ctrl;
  logic [CountWidth-1:0] rdata;
  logic [CountWidth-1:0] cnt;
  logic            cnt_full;
  logic            cnt_zero;
  logic            ram_we;
  logic [CountWidth-1:0] wdata;
  status_e         fin_stat;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // level search over the bitmap
  tpsa_search #(
    .NumLevels(NumLevels)
  ) u_search (
    .occ_i  (occ_q),
    .func_i (func_e'(s_axis_tuser)),
    .req_i  (s_axis_tdata[ReqW-1:0]),
    .lvl_o  (srch_lvl),
    .ctrl_o (srch_ctrl)
  );

  // per-level count storage
  tpsa_ram #(
    .Width(CountWidth),
    .Depth(NumLevels)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (lvl_q),
    .wdata_i (wdata),
    .re_i    (in_xfer),
    .raddr_i (srch_lvl),
    .rdata_o (rdata)
  );

  // update step: runs once the output register is free
  assign finish   = (state_q == S_RMW) && (!out_vld_q || m_axis_tready);
  assign cnt      = occ_q[lvl_q] ? rdata : '0;
  assign cnt_full = (cnt == {CountWidth{1'b1}});
  assign cnt_zero = !occ_q[lvl_q];

  always_comb begin
    ram_we   = 1'b0;
    wdata    = cnt;
    occ_d    = occ_q;
    fin_stat = ctrl_q.status;
    if (finish) begin
      case (ctrl_q.op)
        OP_ADD: begin
          if (cnt_full) begin
            fin_stat = STAT_FULL;
          end else begin
            ram_we       = 1'b1;
            wdata        = cnt + CountWidth'(1);
            occ_d[lvl_q] = 1'b1;
          end
        end
        OP_REM: begin
          if (cnt_zero) begin
            fin_stat = STAT_EMPTY;
          end else begin
            ram_we       = 1'b1;
            wdata        = cnt - CountWidth'(1);
            occ_d[lvl_q] = (cnt != CountWidth'(1));
          end
        end
        default: begin
          ram_we = 1'b0;
        end
      endcase
    end
  end

  // sequencing
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_RMW;
        end
      end
      S_RMW: begin
        if (finish) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output valid
  always_comb begin
    out_vld_d = out_vld_q;
    if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
    if (finish) begin
      out_vld_d = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      occ_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      occ_q     <= occ_d;
      out_vld_q <= out_vld_d;
    end
  end

  // stage and result payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      lvl_q  <= srch_lvl;
      ctrl_q <= srch_ctrl;
    end
    if (finish) begin
      out_prio_q <= PrioW'(lvl_q);
      out_stat_q <= fin_stat;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_stat_q, out_prio_q};

`ifndef ASSERT_OFF
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_accept_to_rmw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == S_RMW))
    else $error("accepted request did not enter update step");

  a_write_in_rmw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_RMW) && !(ctrl_q.op == OP_NONE))
    else $error("count write outside update step");

  a_add_sets_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && (ctrl_q.op == OP_ADD)) |=> occ_q[$past(lvl_q)])
    else $error("occupancy bit not set after add");
`endif

endmodule

`default_nettype wire

// ===== rtl/tpsa_ram.sv =====
// generic single write port ram with one registered read port
// no dependencies
`default_nettype none

module tpsa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tpsa_search.sv =====
// level selection: priority encoders over the occupancy bitmap
// depends on tpsa_pkg
`default_nettype none

module tpsa_search
  import tpsa_pkg::*;
#(
  parameter int unsigned NumLevels = NumLevelsDef
) (
  input  wire logic [NumLevels-1:0]         occ_i,
  input  wire func_e                        func_i,
  input  wire logic [ReqW-1:0]              req_i,
  output logic      [$clog2(NumLevels)-1:0] lvl_o,
  output srch_ctrl_t                        ctrl_o
);

  localparam int unsigned LvlW = $clog2(NumLevels);
  localparam logic [LvlW-1:0] LvlTop = LvlW'(NumLevels - 1);

  logic            req_ok;
  logic [LvlW-1:0] start;
  logic            any_occ;
  logic [LvlW-1:0] hi_occ;
  logic [LvlW-1:0] lo_occ;
  logic            up_found;
  logic [LvlW-1:0] up_free;
  logic            dn_found;
  logic [LvlW-1:0] dn_free;

  assign req_ok = int'(req_i) < NumLevels;
  assign start  = req_ok ? LvlW'(req_i) : LvlTop;

  // encoders: highest and lowest occupied level
  always_comb begin
    any_occ = 1'b0;
    hi_occ  = '0;
    lo_occ  = '0;
    for (int i = 0; i < NumLevels; i++) begin
      if (occ_i[i]) begin
        any_occ = 1'b1;
        hi_occ  = LvlW'(i);
      end
    end
    for (int i = NumLevels - 1; i >= 0; i--) begin
      if (occ_i[i]) begin
        lo_occ = LvlW'(i);
      end
    end
  end

  // encoders: first free level at or after start, and at or before start
  always_comb begin
    up_found = 1'b0;
    up_free  = '0;
    dn_found = 1'b0;
    dn_free  = '0;
    for (int i = NumLevels - 1; i >= 0; i--) begin
      if (!occ_i[i] && (i >= int'(start))) begin
        up_found = 1'b1;
        up_free  = LvlW'(i);
      end
    end
    for (int i = 0; i < NumLevels; i++) begin
      if (!occ_i[i] && (i <= int'(start))) begin
        dn_found = 1'b1;
        dn_free  = LvlW'(i);
      end
    end
  end

  // choose level and preliminary status per operation
  always_comb begin
    lvl_o         = '0;
    ctrl_o.op     = OP_ADD;
    ctrl_o.status = STAT_OK;
    case (func_i)
      FUNC_ADD_GIVEN: begin
        if (req_ok) begin
          lvl_o = start;
        end else begin
          ctrl_o.op     = OP_NONE;
          ctrl_o.status = STAT_RANGE;
        end
      end
      FUNC_ADD_LOWEST: begin
        if (any_occ) begin
          if (hi_occ == LvlTop) begin
            lvl_o         = LvlTop;
            ctrl_o.status = STAT_SAT;
          end else begin
            lvl_o = hi_occ + LvlW'(1);
          end
        end
      end
      FUNC_ADD_HIGHEST: begin
        if (any_occ) begin
          if (lo_occ == '0) begin
            ctrl_o.status = STAT_SAT;
          end else begin
            lvl_o = lo_occ - LvlW'(1);
          end
        end
      end
      FUNC_ADD_BELOW: begin
        if (req_ok && up_found) begin
          lvl_o = up_free;
        end else begin
          lvl_o         = LvlTop;
          ctrl_o.status = STAT_SAT;
        end
      end
      FUNC_ADD_ABOVE: begin
        if (dn_found) begin
          lvl_o = dn_free;
        end else begin
          ctrl_o.status = STAT_SAT;
        end
        if (!req_ok) begin
          ctrl_o.status = STAT_SAT;
        end
      end
      FUNC_REMOVE: begin
        if (req_ok) begin
          lvl_o     = start;
          ctrl_o.op = OP_REM;
        end else begin
          ctrl_o.op     = OP_NONE;
          ctrl_o.status = STAT_RANGE;
        end
      end
      default: begin
        ctrl_o.op     = OP_NONE;
        ctrl_o.status = STAT_RANGE;
      end
    endcase
  end

endmodule

`default_nettype wire
